@@ rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared widths, codes, records and default parameter values for the
// allocator core and its segment cells.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // Field widths fixed by the interface and the segment record.
   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 23;
   localparam int OFFSET_W = 22;
   localparam int NEED_W   = SIZE_W + 1;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   // Default parameter values and register reset value.
   localparam int HEAP_BYTES_DEF   = 4194304;
   localparam int HEADER_BYTES_DEF = 12;
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'h0040_0000;

   // Smallest payload left behind by a split, on top of a header.
   localparam int SPLIT_SLACK = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK      = 2'd0,
      STS_OOM     = 2'd1,
      STS_ZERO    = 2'd2,
      STS_UNKNOWN = 2'd3
   } status_type;

   // What the travelling probe is doing as it passes a cell.
   typedef enum logic [1:0] {
      PM_SCAN   = 2'd0,
      PM_INSERT = 2'd1,
      PM_DELETE = 2'd2,
      PM_IDLE   = 2'd3
   } probe_mode_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_RUN    = 2'd1,
      FSM_FINISH = 2'd2
   } fsm_state_type;

   // One segment record as held by a cell.
   typedef struct packed {
      logic                valid;
      logic                free;
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   size;
   } seg_type;

   // Operation broadcast to every cell while the probe travels.
   typedef struct packed {
      cmd_type             cmd;
      logic [NEED_W-1:0]   need;
      logic [NEED_W-1:0]   split_thr;
      logic [NEED_W-1:0]   need_hdr;
      logic [OFFSET_W-1:0] target;
      logic                target_ok;
      logic                full;
   } op_type;

   // Probe handed from cell to cell, one cell per cycle.
   typedef struct packed {
      logic              live;
      probe_mode_type    mode;
      logic              found;
      logic              split;
      logic [1:0]        del_cnt;
      logic              prev_free;
      logic [SIZE_W-1:0] prev_size;
      logic [SIZE_W-1:0] sum;
      logic [OFFSET_W-1:0] res_offset;
      seg_type           carry;
   } probe_type;

   // Size write from a cell into its left neighbour when merging.
   typedef struct packed {
      logic              valid;
      logic [SIZE_W-1:0] size;
   } grow_type;

endpackage

@@ rtl/ffha_cell.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator segment cell
// Holds one segment record and acts on it when the probe passes: first-fit
// test and split, address match and merge, free byte summing, and the
// insert and delete waves that move records along the chain.
// ----------------------------------------------------------------------------
module ffha_cell #(
   parameter int   HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int   HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter logic FIRST        = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  ffha_pkg::op_type    op,
   input  ffha_pkg::probe_type probe_in,
   output ffha_pkg::probe_type probe_out,
   output ffha_pkg::seg_type   seg_out,
   input  ffha_pkg::seg_type   seg_r1,
   input  ffha_pkg::seg_type   seg_r2,
   input  ffha_pkg::grow_type  grow_in,
   output ffha_pkg::grow_type  grow_out
);

   localparam logic [ffha_pkg::SIZE_W-1:0] HDR_SZ  = ffha_pkg::SIZE_W'(HEADER_BYTES);
   localparam logic [ffha_pkg::SIZE_W-1:0] HDR2_SZ = ffha_pkg::SIZE_W'(2 * HEADER_BYTES);
   localparam logic [ffha_pkg::SIZE_W-1:0] INIT_SZ =
      ffha_pkg::SIZE_W'(HEAP_BYTES - HEADER_BYTES);

   ffha_pkg::seg_type   seg_ff, seg_in;
   ffha_pkg::probe_type probe_ff, probe_nx;
   logic fit, do_split, match, nxt;

   // Local tests on the held record.
   assign fit      = seg_ff.valid && seg_ff.free && ({1'b0, seg_ff.size} >= op.need);
   assign do_split = ({1'b0, seg_ff.size} >= op.split_thr) && !op.full;
   assign match    = seg_ff.valid && op.target_ok && (seg_ff.offset == op.target);
   assign nxt      = seg_r1.valid && seg_r1.free;

   // Record and probe update.
   always_comb begin
      seg_in   = seg_ff;
      probe_nx = probe_ff;
      grow_out = '0;
      if (grow_in.valid) begin
         seg_in.size = grow_in.size;
      end
      if (probe_ff.live) begin
         unique case (probe_ff.mode)
            ffha_pkg::PM_SCAN: begin
               unique case (op.cmd)
                  ffha_pkg::CMD_ALLOC: begin
                     if (fit) begin
                        probe_nx.found      = 1'b1;
                        probe_nx.res_offset = seg_ff.offset;
                        seg_in.free         = 1'b0;
                        if (do_split) begin
                           seg_in.size           = op.need[ffha_pkg::SIZE_W-1:0];
                           probe_nx.carry.valid  = 1'b1;
                           probe_nx.carry.free   = 1'b1;
                           probe_nx.carry.offset =
                              seg_ff.offset + op.need_hdr[ffha_pkg::OFFSET_W-1:0];
                           probe_nx.carry.size   =
                              seg_ff.size - op.need_hdr[ffha_pkg::SIZE_W-1:0];
                           probe_nx.split        = 1'b1;
                           probe_nx.mode         = ffha_pkg::PM_INSERT;
                        end else begin
                           probe_nx.mode = ffha_pkg::PM_IDLE;
                        end
                     end
                  end
                  ffha_pkg::CMD_FREE: begin
                     if (match) begin
                        probe_nx.found = 1'b1;
                        if (probe_ff.prev_free) begin
                           // Fold this segment, and the next if free, into the left one.
                           grow_out.valid   = 1'b1;
                           grow_out.size    = probe_ff.prev_size + seg_ff.size +
                                              (nxt ? seg_r1.size + HDR2_SZ : HDR_SZ);
                           probe_nx.del_cnt = nxt ? 2'd2 : 2'd1;
                           seg_in           = nxt ? seg_r2 : seg_r1;
                           probe_nx.mode    = ffha_pkg::PM_DELETE;
                        end else begin
                           seg_in.free = 1'b1;
                           if (nxt) begin
                              seg_in.size      = seg_ff.size + seg_r1.size + HDR_SZ;
                              probe_nx.del_cnt = 2'd1;
                              probe_nx.mode    = ffha_pkg::PM_DELETE;
                           end else begin
                              probe_nx.mode = ffha_pkg::PM_IDLE;
                           end
                        end
                     end else begin
                        probe_nx.prev_free = seg_ff.valid && seg_ff.free;
                        probe_nx.prev_size = seg_ff.size;
                     end
                  end
                  ffha_pkg::CMD_QUERY: begin
                     if (seg_ff.valid && seg_ff.free) begin
                        probe_nx.sum = probe_ff.sum + seg_ff.size;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ffha_pkg::PM_INSERT: begin
               // Take the carried record and hand the old one on to the right.
               seg_in         = probe_ff.carry;
               probe_nx.carry = seg_ff;
            end
            ffha_pkg::PM_DELETE: begin
               seg_in = (probe_ff.del_cnt == 2'd2) ? seg_r2 : seg_r1;
            end
            ffha_pkg::PM_IDLE: begin
            end
         endcase
      end
   end

   // Record and probe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
         if (FIRST) begin
            seg_ff.valid  <= 1'b1;
            seg_ff.free   <= 1'b1;
            seg_ff.offset <= '0;
            seg_ff.size   <= INIT_SZ;
         end else begin
            seg_ff <= '0;
         end
      end else begin
         probe_ff <= probe_in;
         seg_ff   <= seg_in;
      end
   end

   assign probe_out = probe_nx;
   assign seg_out   = seg_ff;

endmodule

@@ rtl/first_fit_heap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Segment table kept in a chain of cells, walked by a probe for first-fit
// allocation, free with coalescing and free byte queries.
// ----------------------------------------------------------------------------
// Each allocate, free or query sends one probe down a chain of MAX_SEGMENTS
// cells, one cell per clock; a zero-size allocate, a free of address zero,
// a query before the first allocate and an unknown command skip the chain
// and go straight to the finish state. Splits move the following records
// one cell along behind the probe and merges one or two cells, within the
// same pass. One item is worked on at a time; the next is taken while the
// previous result still waits on the rsp_ channel.
module first_fit_heap_allocator_core #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ffha_pkg::ADDR_W-1:0]     csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ffha_pkg::CMD_W-1:0]      req_cmd,
   input  logic [ffha_pkg::SIZE_W-1:0]     req_request_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]     req_release_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ffha_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]     rsp_block_address,
   output logic [ffha_pkg::SIZE_W-1:0]     rsp_free_bytes
);

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
   localparam logic [ffha_pkg::NEED_W-1:0] RND = ffha_pkg::NEED_W'(3);

   ffha_pkg::fsm_state_type state_ff, state_in;
   logic [ffha_pkg::ADDR_W-1:0] base_hdr_ff, base_hdr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        started_ff, started_in;
   ffha_pkg::op_type            op_ff, op_in;
   logic [ffha_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ffha_pkg::ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [ffha_pkg::SIZE_W-1:0]   res_free_ff, res_free_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ffha_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [ffha_pkg::SIZE_W-1:0]   rsp_free_ff;

   ffha_pkg::cmd_type   cmd;
   logic                accept, scan, load_rsp, exit_live;
   logic [ffha_pkg::NEED_W-1:0] need;
   logic [ffha_pkg::ADDR_W-1:0] target;

   ffha_pkg::seg_type   seg_arr   [0:MAX_SEGMENTS+1];
   ffha_pkg::probe_type probe_arr [0:MAX_SEGMENTS];
   ffha_pkg::grow_type  grow_arr  [0:MAX_SEGMENTS];

   // Chain of segment cells; the probe enters at cell 0.
   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      ffha_cell #(
         .HEAP_BYTES   (HEAP_BYTES),
         .HEADER_BYTES (HEADER_BYTES),
         .FIRST        (k == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op_ff),
         .probe_in  (probe_arr[k]),
         .probe_out (probe_arr[k+1]),
         .seg_out   (seg_arr[k]),
         .seg_r1    (seg_arr[k+1]),
         .seg_r2    (seg_arr[k+2]),
         .grow_in   (grow_arr[k+1]),
         .grow_out  (grow_arr[k])
      );
   end

   // Empty records past the end of the chain.
   assign seg_arr[MAX_SEGMENTS]   = '0;
   assign seg_arr[MAX_SEGMENTS+1] = '0;
   assign grow_arr[MAX_SEGMENTS]  = '0;

   // Input transfer and operation set-up.
   assign cmd       = ffha_pkg::cmd_type'(req_cmd);
   assign accept    = req_valid && req_ready;
   assign exit_live = probe_arr[MAX_SEGMENTS].live;
   assign need      = ({1'b0, req_request_bytes} + RND) & ~RND;
   assign target    = req_release_address - base_hdr_ff;

   always_comb begin
      scan = 1'b0;
      unique case (cmd)
         ffha_pkg::CMD_ALLOC: scan = (req_request_bytes != '0);
         ffha_pkg::CMD_FREE:  scan = (req_release_address != '0);
         ffha_pkg::CMD_QUERY: scan = started_ff;
         default:             scan = 1'b0;
      endcase
   end

   always_comb begin
      op_in = op_ff;
      if (accept) begin
         op_in.cmd       = cmd;
         op_in.need      = need;
         op_in.split_thr = need + ffha_pkg::NEED_W'(HEADER_BYTES + ffha_pkg::SPLIT_SLACK);
         op_in.need_hdr  = need + ffha_pkg::NEED_W'(HEADER_BYTES);
         op_in.target    = target[ffha_pkg::OFFSET_W-1:0];
         op_in.target_ok = (target[ffha_pkg::ADDR_W-1:ffha_pkg::OFFSET_W] == '0);
         op_in.full      = (count_ff == CNT_MAX);
      end
   end

   // Probe launched into the first cell.
   always_comb begin
      probe_arr[0]      = '0;
      probe_arr[0].live = accept && scan;
      probe_arr[0].mode = ffha_pkg::PM_SCAN;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = scan ? ffha_pkg::FSM_RUN : ffha_pkg::FSM_FINISH;
            end
         end
         ffha_pkg::FSM_RUN: begin
            if (exit_live) begin
               state_in = ffha_pkg::FSM_FINISH;
            end
         end
         ffha_pkg::FSM_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ffha_pkg::FSM_IDLE;
            end
         end
         default: state_in = ffha_pkg::FSM_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_ready = (state_ff == ffha_pkg::FSM_IDLE);
      load_rsp  = (state_ff == ffha_pkg::FSM_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // Result, segment count and start flag.
   always_comb begin
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_free_in   = res_free_ff;
      count_in      = count_ff;
      started_in    = started_ff;
      if (accept) begin
         res_status_in = ffha_pkg::STS_OK;
         res_addr_in   = '0;
         res_free_in   = '0;
         if (cmd == ffha_pkg::CMD_ALLOC) begin
            started_in = 1'b1;
            if (req_request_bytes == '0) begin
               res_status_in = ffha_pkg::STS_ZERO;
            end
         end
         if (cmd == ffha_pkg::CMD_QUERY && !started_ff) begin
            res_free_in = ffha_pkg::SIZE_W'(HEAP_BYTES);
         end
      end
      if (exit_live) begin
         unique case (op_ff.cmd)
            ffha_pkg::CMD_ALLOC: begin
               if (probe_arr[MAX_SEGMENTS].found) begin
                  res_status_in = ffha_pkg::STS_OK;
                  res_addr_in   = base_hdr_ff +
                     ffha_pkg::ADDR_W'(probe_arr[MAX_SEGMENTS].res_offset);
               end else begin
                  res_status_in = ffha_pkg::STS_OOM;
               end
               count_in = count_ff + CNT_W'(probe_arr[MAX_SEGMENTS].split);
            end
            ffha_pkg::CMD_FREE: begin
               res_status_in = probe_arr[MAX_SEGMENTS].found ? ffha_pkg::STS_OK :
                                                               ffha_pkg::STS_UNKNOWN;
               count_in = count_ff - CNT_W'(probe_arr[MAX_SEGMENTS].del_cnt);
            end
            ffha_pkg::CMD_QUERY: begin
               res_free_in = probe_arr[MAX_SEGMENTS].sum;
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration register, kept with the header size already added.
   always_comb begin
      base_hdr_in = base_hdr_ff;
      if (csr_wr_en) begin
         base_hdr_in = csr_wr_data + ffha_pkg::ADDR_W'(HEADER_BYTES);
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::FSM_IDLE;
         base_hdr_ff  <= ffha_pkg::HEAP_BASE_RESET + ffha_pkg::ADDR_W'(HEADER_BYTES);
         count_ff     <= CNT_W'(1);
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_hdr_ff  <= base_hdr_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_free_ff   <= res_free_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_free_ff   <= res_free_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_free_bytes    = rsp_free_ff;

   // The segment count stays between one and the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_MAX))
      else $error("segment count out of range");

   // A probe leaves the chain only while a pass is running.
   a_exit_in_run: assert property (@(posedge clock) disable iff (reset)
      exit_live |-> (state_ff == ffha_pkg::FSM_RUN))
      else $error("probe left the chain outside a pass");

   // The first cell has no left neighbour to merge into.
   a_no_head_grow: assert property (@(posedge clock) disable iff (reset)
      !grow_arr[0].valid)
      else $error("merge into a segment before the first");

   // A pass ends only when the probe leaves the last cell.
   a_run_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ffha_pkg::FSM_RUN) && !exit_live) |=> (state_ff == ffha_pkg::FSM_RUN))
      else $error("pass ended before the probe left the chain");

endmodule

@@ verif/tb_first_fit_heap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator core testbench
// Drives allocate, free and query transfers into the core. Each result is
// compared, field by field, with the output of a behavioural segment table
// that the testbench keeps alongside the core. A short table of directed
// rows comes first, followed by random traffic of all four commands with
// stalls on both channels. The heap base register is changed between phases.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_core;

   localparam int HEAP  = ffha_pkg::HEAP_BYTES_DEF;
   localparam int HDR   = ffha_pkg::HEADER_BYTES_DEF;
   localparam int NSEG  = ffha_pkg::MAX_SEGMENTS_DEF;
   localparam int DRAIN = 4 * NSEG;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      ffha_pkg::status_type status;
      logic [31:0]          addr;
      logic [22:0]          freeb;
   } outcome_type;

   typedef struct {
      ffha_pkg::cmd_type cmd;
      logic [22:0]       req;
      logic [31:0]       rel;
      logic              typed;
      outcome_type       want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = '0;
   logic [22:0] req_request_bytes = '0;
   logic [31:0] req_release_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_block_address;
   logic [22:0] rsp_free_bytes;

   first_fit_heap_allocator_core u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_request_bytes(req_request_bytes),
      .req_release_address(req_release_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_block_address(rsp_block_address),
      .rsp_free_bytes(rsp_free_bytes)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the segment table and the heap base register.
   logic [31:0] base_shadow;
   logic [22:0] seg_size [NSEG];
   logic [21:0] seg_off  [NSEG];
   logic        seg_free [NSEG];
   int          seg_count;
   logic        started;

   outcome_type pending_results[$];
   logic [31:0] live_blocks[$];
   int          errors = 0;
   int          quiet_cycles = 0;
   int          rsp_gap = 0;
   logic        rsp_hold = 1'b0;
   logic        no_idle = 1'b0;

   function automatic logic [31:0] seg_payload(int i);
      return base_shadow + 32'(seg_off[i]) + 32'(HDR);
   endfunction

   task automatic table_clear();
      for (int i = 0; i < NSEG; i++) begin
         seg_size[i] = '0;
         seg_off[i]  = '0;
         seg_free[i] = 1'b0;
      end
      seg_size[0] = 23'(HEAP - HDR);
      seg_free[0] = 1'b1;
      seg_count   = 1;
      started     = 1'b0;
   endtask

   task automatic coalesce();
      int i;
      i = 0;
      while (i + 1 < seg_count) begin
         if (seg_free[i] && seg_free[i+1]) begin
            seg_size[i] = seg_size[i] + 23'(HDR) + seg_size[i+1];
            for (int j = i + 1; j + 1 < seg_count; j++) begin
               seg_size[j] = seg_size[j+1];
               seg_off[j]  = seg_off[j+1];
               seg_free[j] = seg_free[j+1];
            end
            seg_count--;
            seg_size[seg_count] = '0;
            seg_off[seg_count]  = '0;
            seg_free[seg_count] = 1'b0;
         end else begin
            i++;
         end
      end
   endtask

   // Works out the result of one operation and updates the shadow table.
   task automatic allocator_step(input ffha_pkg::cmd_type c, input logic [22:0] req,
                                 input logic [31:0] rel, output outcome_type o);
      logic [23:0] need;
      o.status = ffha_pkg::STS_OK;
      o.addr   = '0;
      o.freeb  = '0;
      case (c)
         ffha_pkg::CMD_ALLOC: begin
            started = 1'b1;
            if (req == 0) begin
               o.status = ffha_pkg::STS_ZERO;
            end else begin
               need = (24'(req) + 24'd3) & ~24'd3;
               o.status = ffha_pkg::STS_OOM;
               for (int i = 0; i < seg_count; i++) begin
                  if (seg_free[i] && 24'(seg_size[i]) >= need) begin
                     if (24'(seg_size[i]) >= need + 24'(HDR + ffha_pkg::SPLIT_SLACK)
                         && seg_count < NSEG) begin
                        for (int j = seg_count; j > i + 1; j--) begin
                           seg_size[j] = seg_size[j-1];
                           seg_off[j]  = seg_off[j-1];
                           seg_free[j] = seg_free[j-1];
                        end
                        seg_off[i+1]  = seg_off[i] + 22'(HDR) + 22'(need);
                        seg_size[i+1] = seg_size[i] - 23'(need) - 23'(HDR);
                        seg_free[i+1] = 1'b1;
                        seg_size[i]   = 23'(need);
                        seg_count++;
                     end
                     seg_free[i] = 1'b0;
                     o.addr   = seg_payload(i);
                     o.status = ffha_pkg::STS_OK;
                     break;
                  end
               end
            end
         end
         ffha_pkg::CMD_FREE: begin
            if (rel != 0) begin
               o.status = ffha_pkg::STS_UNKNOWN;
               for (int i = 0; i < seg_count; i++) begin
                  if (seg_payload(i) == rel) begin
                     seg_free[i] = 1'b1;
                     coalesce();
                     o.status = ffha_pkg::STS_OK;
                     break;
                  end
               end
            end
         end
         ffha_pkg::CMD_QUERY: begin
            if (!started) begin
               o.freeb = 23'(HEAP);
            end else begin
               for (int i = 0; i < seg_count; i++)
                  if (seg_free[i]) o.freeb = o.freeb + seg_size[i];
            end
         end
         default: ;
      endcase
   endtask

   // Receiver: random stall bursts, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= rsp_gap - 1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= int'($urandom_range(0, 3));
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: status %0d", rsp_status);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_block_address !== e.addr) begin
               $error("block_address: expected %h, actual %h", e.addr,
                      rsp_block_address);
               errors++;
            end
            if (rsp_free_bytes !== e.freeb) begin
               $error("free_bytes: expected %0d, actual %0d", e.freeb,
                      rsp_free_bytes);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one item and waits for its transfer; the prediction is made then.
   // Valid stays high after the transfer so that the next item can follow at
   // once; wait_empty and idle gaps lower it.
   task automatic send(input ffha_pkg::cmd_type c, input logic [22:0] req,
                       input logic [31:0] rel, input logic typed,
                       input outcome_type want);
      outcome_type o;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= c;
      req_request_bytes   <= req;
      req_release_address <= rel;
      do @(posedge clock); while (!req_ready);
      allocator_step(c, req, rel, o);
      if (typed && (o.status !== want.status || o.addr !== want.addr
                    || o.freeb !== want.freeb)) begin
         $error("directed row disagrees with prediction for cmd %0d", c);
         errors++;
      end
      pending_results.push_back(o);
      if (c == ffha_pkg::CMD_ALLOC && o.status == ffha_pkg::STS_OK)
         live_blocks.push_back(o.addr);
   endtask

   task automatic wait_empty();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_base(input logic [31:0] value);
      wait_empty();
      repeat (NSEG + 4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      base_shadow = value;
      live_blocks.delete();
   endtask

   // Frees every live block so that the next phase starts from a clean heap.
   task automatic release_all();
      outcome_type none;
      none = '{ffha_pkg::STS_OK, '0, '0};
      while (live_blocks.size() != 0)
         send(ffha_pkg::CMD_FREE, '0, live_blocks.pop_front(), 1'b0, none);
   endtask

   task automatic random_phase(int n);
      outcome_type none;
      int k;
      logic [31:0] rel;
      logic [22:0] req;
      none = '{ffha_pkg::STS_OK, '0, '0};
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 45) begin
            case ($urandom_range(0, 9))
               0:       req = 23'($urandom());
               1:       req = 23'($urandom_range(0, 3));
               2:       req = 23'($urandom_range(65536, 1048576));
               default: req = 23'($urandom_range(1, 4096));
            endcase
            send(ffha_pkg::CMD_ALLOC, req, '0, 1'b0, none);
         end else if (k < 82 && live_blocks.size() != 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            rel = live_blocks[k];
            live_blocks.delete(k);
            send(ffha_pkg::CMD_FREE, '0, rel, 1'b0, none);
         end else if (k < 88) begin
            rel = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom();
            send(ffha_pkg::CMD_FREE, 23'($urandom()), rel, 1'b0, none);
         end else if (k < 96) begin
            send(ffha_pkg::CMD_QUERY, 23'($urandom()), $urandom(), 1'b0, none);
         end else begin
            send(ffha_pkg::CMD_NONE, 23'($urandom()), $urandom(), 1'b0, none);
         end
      end
   endtask

   // Directed rows: reset state, extremes, error codes and special cases.
   localparam logic [31:0] B0 = ffha_pkg::HEAP_BASE_RESET + 32'(HDR);
   row_type directed[] = '{
      '{ffha_pkg::CMD_QUERY, 23'd0,      32'd0,        1'b1,
        '{ffha_pkg::STS_OK, 32'd0, 23'(HEAP)}},
      '{ffha_pkg::CMD_NONE,  23'h7FFFFF, 32'hFFFFFFFF, 1'b1,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_FREE,  23'd0,      32'd0,        1'b1,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_ALLOC, 23'd0,      32'd0,        1'b1,
        '{ffha_pkg::STS_ZERO, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_QUERY, 23'd0,      32'd0,        1'b1,
        '{ffha_pkg::STS_OK, 32'd0, 23'(HEAP - HDR)}},
      '{ffha_pkg::CMD_ALLOC, 23'h7FFFFF, 32'd0,        1'b1,
        '{ffha_pkg::STS_OOM, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_ALLOC, 23'(HEAP),  32'd0,        1'b1,
        '{ffha_pkg::STS_OOM, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_FREE,  23'd0,      32'hFFFFFFFF, 1'b1,
        '{ffha_pkg::STS_UNKNOWN, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_ALLOC, 23'd1,      32'd0,        1'b1,
        '{ffha_pkg::STS_OK, B0, 23'd0}},
      '{ffha_pkg::CMD_ALLOC, 23'd5,      32'd0,        1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_ALLOC, 23'd20,     32'd0,        1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_FREE,  23'd0,      B0 + 32'd16,  1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_FREE,  23'd0,      B0 + 32'd16,  1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_ALLOC, 23'd8,      32'd0,        1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_QUERY, 23'd0,      32'd0,        1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_FREE,  23'd0,      B0,           1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_ALLOC, 23'(HEAP-HDR-2), 32'd0,   1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}},
      '{ffha_pkg::CMD_QUERY, 23'd0,      32'd0,        1'b0,
        '{ffha_pkg::STS_OK, 32'd0, 23'd0}}
   };

   initial begin
      outcome_type none;
      none = '{ffha_pkg::STS_OK, '0, '0};
      base_shadow = ffha_pkg::HEAP_BASE_RESET;
      table_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send(directed[i].cmd, directed[i].req, directed[i].rel,
              directed[i].typed, directed[i].want);
      release_all();

      // Fill the table beyond its depth with small blocks, so that the last
      // split is refused and a whole segment is handed out.
      for (int i = 0; i < NSEG + 4; i++)
         send(ffha_pkg::CMD_ALLOC, 23'($urandom_range(1, 64)), '0, 1'b0, none);
      release_all();

      // Long receiver hold-off while the sender keeps offering.
      fork
         begin
            rsp_hold = 1'b1;
            repeat (600) @(posedge clock);
            rsp_hold = 1'b0;
         end
         random_phase(30);
      join
      wait_empty();
      release_all();

      write_base(32'd0);
      random_phase(300);
      release_all();
      write_base(32'hFFFFFFFF);
      random_phase(300);
      release_all();
      write_base($urandom());
      random_phase(300);
      release_all();
      write_base(32'hFFC0_0000);
      random_phase(250);
      no_idle = 1'b1;
      random_phase(150);

      wait_empty();
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
